// ===== hw/rtl/edr_pkg.sv =====
`default_nettype none
package edr_pkg;

    // Bytes held for each of R and S. Must be a power of two: the store
    // wraps its write and read pointers modulo this value.
    localparam int HALF_BYTES        = 32;
    localparam int MAX_ELEMENT_BYTES = 33;

    localparam int HALF_W  = $clog2(HALF_BYTES);
    localparam int CNT_W   = $clog2(MAX_ELEMENT_BYTES + 1);
    localparam int IDX_W   = HALF_W + 1;
    localparam int ADDR_W  = HALF_W + 2;
    localparam int DEPTH   = 4 * HALF_BYTES;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [7:0]         TAG_SEQUENCE  = 8'h30;
    localparam logic [7:0]         TAG_INTEGER   = 8'h02;
    localparam logic [7:0]         LONG_FORM_ONE = 8'h81;
    localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(2 * HALF_BYTES - 1);

    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_SEQ_LEN_LONG,
        PH_R_TAG,
        PH_R_LEN,
        PH_R_LEN_LONG,
        PH_R_BODY,
        PH_S_TAG,
        PH_S_LEN,
        PH_S_LEN_LONG,
        PH_S_BODY,
        PH_DONE
    } t_phase;

    // Write request from the parser into the value store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // A finished signature handed from the parser to the readout.
    typedef struct packed {
        logic             valid;
        logic             error;
        logic [CNT_W-1:0] cnt_r;
        logic [CNT_W-1:0] cnt_s;
        logic             bank;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/ecdsa_der_to_raw_signature_unit.sv =====
`default_nettype none
// DER to raw ECDSA signature converter (P-256 layout).
// Input channel: one DER byte per beat on i_in_byte, with i_in_last marking the
// final byte of a signature. A beat is taken when i_in_valid is high and
// o_in_stall is low. Bytes are taken at one per cycle; only a final byte can
// be stalled, and only while the previous signature is still being read out.
// Output channel: 64 beats, R then S, big-endian, with o_out_last on the last
// one, or a single beat with o_out_error and o_out_last set and a zero byte if
// the input was malformed. Results pass the job, read and output registers;
// beats follow one per cycle while i_out_stall is low.
// R and S bytes are written into a dual-bank value store as they arrive; the
// readout streams one bank while the parser fills the other, so all but the
// final byte of a following signature can be taken while results are still
// being delivered. The output pace is set by the single read port of that store.
// When the receiver raises i_out_stall the output beat and the read data
// behind it hold, and the readout pauses. Reset is synchronous and active low;
// it returns the parser to waiting for a sequence tag and drops any pending
// output. The store needs no clearing, since unwritten bytes read as padding.
module ecdsa_der_to_raw_signature_unit
    import edr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_out_byte,
    output logic            o_out_last,
    output logic            o_out_error
);

    t_wr               wr;
    t_job              job;
    logic              busy;
    logic              accept;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rdata;

    // The final byte waits until the readout has issued every read of the
    // bank that the parser is about to reuse.
    assign o_in_stall = i_in_last && busy;
    assign accept     = i_in_valid && !o_in_stall;

    edr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_wr     (wr),
        .o_job    (job)
    );

    edr_value_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rdata   (rdata)
    );

    edr_readout u_readout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/edr_value_store.sv =====
`default_nettype none
module edr_value_store
    import edr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_wr               i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read data holds while no new read is issued, which lets the readout
    // keep a stalled byte in place.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/edr_parser.sv =====
`default_nettype none
module edr_parser
    import edr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_wr             o_wr,
    output t_job            o_job
);

    t_phase               r_phase, n_phase;
    logic [7:0]           r_seq_len, n_seq_len;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]     r_remaining, n_remaining;
    logic [CNT_W-1:0]     r_cnt_r, n_cnt_r;
    logic [CNT_W-1:0]     r_cnt_s, n_cnt_s;
    logic                 r_error, n_error;
    logic                 r_bank, n_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEQ_TAG;
            r_seq_len   <= '0;
            r_count     <= '0;
            r_remaining <= '0;
            r_cnt_r     <= '0;
            r_cnt_s     <= '0;
            r_error     <= 1'b0;
            r_bank      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seq_len   <= n_seq_len;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_cnt_r     <= n_cnt_r;
            r_cnt_s     <= n_cnt_s;
            r_error     <= n_error;
            r_bank      <= n_bank;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_seq_len   = r_seq_len;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_cnt_r     = r_cnt_r;
        n_cnt_s     = r_cnt_s;
        n_error     = r_error;
        n_bank      = r_bank;
        o_wr        = '0;
        o_job       = '0;

        if (i_accept) begin
            if (!r_error) begin
                // Everything after the sequence header counts toward its length.
                if (r_phase != PH_SEQ_TAG && r_phase != PH_SEQ_LEN &&
                    r_phase != PH_SEQ_LEN_LONG && r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end

                case (r_phase)
                    PH_SEQ_TAG: begin
                        if (i_byte == TAG_SEQUENCE) n_phase = PH_SEQ_LEN;
                        else n_error = 1'b1;
                    end
                    PH_SEQ_LEN: begin
                        if (!i_byte[7]) begin
                            n_seq_len = i_byte;
                            n_phase   = PH_R_TAG;
                        end else if (i_byte == LONG_FORM_ONE) begin
                            n_phase = PH_SEQ_LEN_LONG;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_SEQ_LEN_LONG: begin
                        n_seq_len = i_byte;
                        n_phase   = PH_R_TAG;
                    end
                    PH_R_TAG, PH_S_TAG: begin
                        if (i_byte != TAG_INTEGER) n_error = 1'b1;
                        else if (r_phase == PH_R_TAG) n_phase = PH_R_LEN;
                        else n_phase = PH_S_LEN;
                    end
                    PH_R_LEN, PH_S_LEN, PH_R_LEN_LONG, PH_S_LEN_LONG: begin
                        if ((r_phase == PH_R_LEN || r_phase == PH_S_LEN) && i_byte[7]) begin
                            if (i_byte != LONG_FORM_ONE) n_error = 1'b1;
                            else if (r_phase == PH_R_LEN) n_phase = PH_R_LEN_LONG;
                            else n_phase = PH_S_LEN_LONG;
                        end else if (i_byte > 8'(MAX_ELEMENT_BYTES)) begin
                            n_error = 1'b1;
                        end else if (i_byte == 8'd0) begin
                            // An empty integer leaves its value at zero.
                            if (r_phase == PH_R_LEN || r_phase == PH_R_LEN_LONG) begin
                                n_phase = PH_S_TAG;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_remaining = i_byte[CNT_W-1:0];
                            if (r_phase == PH_R_LEN || r_phase == PH_R_LEN_LONG) begin
                                n_phase = PH_R_BODY;
                            end else begin
                                n_phase = PH_S_BODY;
                            end
                        end
                    end
                    PH_R_BODY: begin
                        o_wr.en     = 1'b1;
                        o_wr.addr   = {r_bank, 1'b0, r_cnt_r[HALF_W-1:0]};
                        o_wr.data   = i_byte;
                        n_cnt_r     = r_cnt_r + 1'b1;
                        n_remaining = r_remaining - 1'b1;
                        if (r_remaining == CNT_W'(1)) n_phase = PH_S_TAG;
                    end
                    PH_S_BODY: begin
                        o_wr.en     = 1'b1;
                        o_wr.addr   = {r_bank, 1'b1, r_cnt_s[HALF_W-1:0]};
                        o_wr.data   = i_byte;
                        n_cnt_s     = r_cnt_s + 1'b1;
                        n_remaining = r_remaining - 1'b1;
                        if (r_remaining == CNT_W'(1)) n_phase = PH_DONE;
                    end
                    PH_DONE: begin
                    end
                    default: begin
                        n_error = 1'b1;
                    end
                endcase
            end

            if (i_last) begin
                o_job.valid = 1'b1;
                o_job.error = n_error || (n_phase != PH_DONE) ||
                              (n_count != {1'b0, n_seq_len});
                o_job.cnt_r = n_cnt_r;
                o_job.cnt_s = n_cnt_s;
                o_job.bank  = r_bank;
                n_phase     = PH_SEQ_TAG;
                n_seq_len   = '0;
                n_count     = '0;
                n_remaining = '0;
                n_cnt_r     = '0;
                n_cnt_s     = '0;
                n_error     = 1'b0;
                n_bank      = ~r_bank;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/edr_readout.sv =====
`default_nettype none
module edr_readout
    import edr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_job              i_job,
    output logic                   o_busy,
    output logic                   o_rd_en,
    output logic      [ADDR_W-1:0] o_rd_addr,
    input  wire logic [7:0]        i_rdata,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [7:0]        o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_error
);

    logic             r_busy;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             r_a_valid, r_a_zero, r_a_last, r_a_error;
    logic             r_o_valid, r_o_last, r_o_error;
    logic [7:0]       r_o_byte;

    logic             out_en, a_en, issue, final_beat;
    logic [CNT_W-1:0] cnt_sel;
    logic [CNT_W:0]   pos;

    assign out_en     = !r_o_valid || !i_out_stall;
    assign a_en       = !r_a_valid || out_en;
    assign issue      = r_busy && a_en;
    assign final_beat = r_job.error || (r_idx == LAST_IDX);

    // Byte i of a value holding cnt bytes sits at (i + cnt) modulo the half
    // width; positions ahead of the first stored byte read as zero padding.
    assign cnt_sel   = r_idx[HALF_W] ? r_job.cnt_s : r_job.cnt_r;
    assign pos       = (CNT_W + 1)'(r_idx[HALF_W-1:0]) + (CNT_W + 1)'(cnt_sel);
    assign o_rd_en   = issue;
    assign o_rd_addr = {r_job.bank, r_idx[HALF_W], pos[HALF_W-1:0]};
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_job.valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (issue) begin
                if (final_beat) r_busy <= 1'b0;
                else r_idx <= r_idx + 1'b1;
            end
            if (a_en) r_a_valid <= issue;
            if (out_en) r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid) r_job <= i_job;
        if (issue) begin
            r_a_zero  <= r_job.error || (pos < (CNT_W + 1)'(HALF_BYTES));
            r_a_last  <= final_beat;
            r_a_error <= r_job.error;
        end
        if (out_en && r_a_valid) begin
            r_o_byte  <= r_a_zero ? 8'd0 : i_rdata;
            r_o_last  <= r_a_last;
            r_o_error <= r_a_error;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_out_last  = r_o_last;
    assign o_out_error = r_o_error;

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_job.valid)
        else $error("new signature handed over while readout busy");

    a_error_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_error) |-> (o_out_last && o_out_byte == 8'd0))
        else $error("error result not a single zero beat");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !out_en) |=> (r_a_valid && $stable(i_rdata)))
        else $error("read stage lost a byte under stall");

    a_busy_ends_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !issue && !i_job.valid) |=> r_busy)
        else $error("readout went idle without issuing its final beat");

endmodule
`default_nettype wire

// ===== dv/ecdsa_der_to_raw_signature_unit_test.sv =====
`timescale 1ns / 1ps

module ecdsa_der_to_raw_signature_unit_test;
    import edr_pkg::*;

    // Generous ceiling on the run length, in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 400;

    // Kinds of damage that can be done to an otherwise well-formed signature.
    typedef enum int {
        FLAW_NONE,
        FLAW_SEQ_TAG,
        FLAW_INT_TAG,
        FLAW_SEQ_LEN,
        FLAW_LEN_FORM,
        FLAW_OVERSIZE,
        FLAW_EARLY_END,
        FLAW_NOISE
    } t_flaw;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_der_beat;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       err;
    } t_raw_beat;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_error;

    ecdsa_der_to_raw_signature_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    // DER bytes waiting to be offered, and raw result beats still owed by the block.
    t_der_beat  pending_der[$];
    t_raw_beat  expected_raw[$];

    // Scratch signature built by the stimulus, with the positions of its length and
    // tag bytes so that individual fields can be damaged afterwards.
    logic [7:0] sig_buf[$];
    int         seq_len_at;
    int         tag_at[2];
    int         len_at[2];

    // Handshake bookkeeping shared between the driver, receiver and monitor.
    bit         idle_on    = 1'b0;
    bit         in_busy    = 1'b0;
    bit         byte_taken = 1'b0;
    int         in_gap     = 0;
    int         out_wait   = 0;
    int         hold_left  = 0;
    bit         hold_req   = 1'b0;

    int         fail_count  = 0;
    int         cycle_count = 0;
    int         sigs_sent   = 0;
    int         bytes_sent  = 0;
    int         raw_checked = 0;
    int         err_checked = 0;

    // Our own copy of the parser state.
    t_phase                  der_phase;
    logic [7:0]              seq_len;
    logic [COUNT_W-1:0]      hdr_count;
    logic [5:0]              elem_left;
    logic [8*HALF_BYTES-1:0] r_val;
    logic [8*HALF_BYTES-1:0] s_val;
    logic                    der_bad;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        der_phase = PH_SEQ_TAG;
        seq_len   = 8'h00;
        hdr_count = '0;
        elem_left = '0;
        r_val     = '0;
        s_val     = '0;
        der_bad   = 1'b0;
    endfunction

    // Handles an element length once it is known, for whichever of R or S is open.
    function automatic void open_element(input logic [7:0] len);
        bit is_r;
        is_r = (der_phase == PH_R_LEN) || (der_phase == PH_R_LEN_LONG);
        if (len > MAX_ELEMENT_BYTES) begin
            der_bad = 1'b1;
        end else if (len == 8'h00) begin
            if (is_r) der_phase = PH_S_TAG;
            else der_phase = PH_DONE;
        end else begin
            elem_left = 6'(len);
            if (is_r) der_phase = PH_R_BODY;
            else der_phase = PH_S_BODY;
        end
    endfunction

    function automatic void parse_der_byte(input logic [7:0] b);
        // Everything after the sequence length header counts towards its check.
        if (der_phase >= PH_R_TAG && hdr_count != COUNT_MAX) hdr_count++;
        case (der_phase)
            PH_SEQ_TAG: begin
                if (b == TAG_SEQUENCE) der_phase = PH_SEQ_LEN;
                else der_bad = 1'b1;
            end
            PH_SEQ_LEN: begin
                if (b < 8'h80) begin
                    seq_len   = b;
                    der_phase = PH_R_TAG;
                end else if (b == LONG_FORM_ONE) begin
                    der_phase = PH_SEQ_LEN_LONG;
                end else begin
                    der_bad = 1'b1;
                end
            end
            PH_SEQ_LEN_LONG: begin
                seq_len   = b;
                der_phase = PH_R_TAG;
            end
            PH_R_TAG: begin
                if (b == TAG_INTEGER) der_phase = PH_R_LEN;
                else der_bad = 1'b1;
            end
            PH_S_TAG: begin
                if (b == TAG_INTEGER) der_phase = PH_S_LEN;
                else der_bad = 1'b1;
            end
            PH_R_LEN, PH_S_LEN: begin
                if (b < 8'h80) begin
                    open_element(b);
                end else if (b == LONG_FORM_ONE) begin
                    if (der_phase == PH_R_LEN) der_phase = PH_R_LEN_LONG;
                    else der_phase = PH_S_LEN_LONG;
                end else begin
                    der_bad = 1'b1;
                end
            end
            PH_R_LEN_LONG, PH_S_LEN_LONG: begin
                open_element(b);
            end
            PH_R_BODY: begin
                r_val = {r_val[8*HALF_BYTES-9:0], b};
                elem_left--;
                if (elem_left == 0) der_phase = PH_S_TAG;
            end
            PH_S_BODY: begin
                s_val = {s_val[8*HALF_BYTES-9:0], b};
                elem_left--;
                if (elem_left == 0) der_phase = PH_DONE;
            end
            PH_DONE: begin
            end
            default: der_bad = 1'b1;
        endcase
    endfunction

    // Feeds one accepted DER beat through the parser and, on the final byte, queues the
    // raw result beats (R then S, most significant byte first) or a single error beat.
    function automatic void convert_der_beat(input logic [7:0] b, input logic last);
        t_raw_beat beat;
        if (!der_bad) parse_der_byte(b);
        if (last) begin
            if (!der_bad && der_phase == PH_DONE && hdr_count == {1'b0, seq_len}) begin
                for (int i = 0; i < 2 * HALF_BYTES; i++) begin
                    if (i < HALF_BYTES) beat.b = r_val[8*(HALF_BYTES-1-i) +: 8];
                    else beat.b = s_val[8*(2*HALF_BYTES-1-i) +: 8];
                    beat.last = (i == 2 * HALF_BYTES - 1);
                    beat.err  = 1'b0;
                    expected_raw = {expected_raw, beat};
                end
            end else begin
                beat.b    = 8'h00;
                beat.last = 1'b1;
                beat.err  = 1'b1;
                expected_raw = {expected_raw, beat};
            end
            clear_parser();
        end
    endfunction

    // Builds a well-formed signature into sig_buf. The sequence length byte simply takes
    // the low eight bits of the body size, which lets an oversized body be built on purpose.
    task automatic build_sig(input int rl, input int sl, input int trail,
                             input bit lf_seq, input bit lf_r, input bit lf_s);
        logic [7:0] body[$];
        int         lens[2];
        bit         lfs[2];
        int         hdr;
        lens = '{rl, sl};
        lfs  = '{lf_r, lf_s};
        body = {};
        for (int k = 0; k < 2; k++) begin
            tag_at[k] = body.size();
            body = {body, TAG_INTEGER};
            if (lfs[k]) body = {body, LONG_FORM_ONE};
            len_at[k] = body.size();
            body = {body, 8'(lens[k])};
            repeat (lens[k]) body = {body, 8'($urandom)};
        end
        repeat (trail) body = {body, 8'($urandom)};
        sig_buf = {};
        sig_buf = {sig_buf, TAG_SEQUENCE};
        if (lf_seq || body.size() > 127) sig_buf = {sig_buf, LONG_FORM_ONE};
        seq_len_at = sig_buf.size();
        sig_buf = {sig_buf, 8'(body.size())};
        hdr = sig_buf.size();
        for (int k = 0; k < 2; k++) begin
            tag_at[k] += hdr;
            len_at[k] += hdr;
        end
        foreach (body[i]) sig_buf = {sig_buf, body[i]};
    endtask

    // Hands sig_buf to the driver, flagging its final byte.
    task automatic send_sig();
        t_der_beat beat;
        foreach (sig_buf[i]) begin
            beat.b    = sig_buf[i];
            beat.last = (i == sig_buf.size() - 1);
            pending_der = {pending_der, beat};
        end
        sigs_sent++;
        bytes_sent += sig_buf.size();
    endtask

    // Element lengths lean towards small values, with full-width values now and then.
    function automatic int pick_len(input bit small_only);
        int p;
        p = $urandom_range(0, 9);
        if (small_only || p < 6) return $urandom_range(0, 8);
        if (p < 9) return $urandom_range(HALF_BYTES - 2, MAX_ELEMENT_BYTES);
        return $urandom_range(9, HALF_BYTES - 3);
    endfunction

    // One random signature: mostly well-formed with random content, otherwise damaged
    // in one field so that each error path of the parser gets exercised.
    task automatic random_signature(input bit small_only, input bit allow_flaw);
        int    pick;
        int    k;
        int    n;
        t_flaw flaw;
        pick = $urandom_range(0, 9);
        build_sig(pick_len(small_only), pick_len(small_only),
                  (pick < 8) ? 0 : $urandom_range(1, 4),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (!allow_flaw || pick < 64) flaw = FLAW_NONE;
        else flaw = t_flaw'(1 + pick % 7);
        case (flaw)
            FLAW_SEQ_TAG: begin
                sig_buf[0] = TAG_SEQUENCE ^ 8'($urandom_range(1, 255));
            end
            FLAW_INT_TAG: begin
                k = tag_at[$urandom_range(0, 1)];
                sig_buf[k] = TAG_INTEGER ^ 8'($urandom_range(1, 255));
            end
            FLAW_SEQ_LEN: begin
                // Off by a few in either direction; straying past 0x7f turns into a
                // bad length form, which is equally an error.
                if ($urandom_range(0, 1)) sig_buf[seq_len_at] += 8'($urandom_range(1, 3));
                else sig_buf[seq_len_at] -= 8'($urandom_range(1, 3));
            end
            FLAW_LEN_FORM: begin
                pick = $urandom_range(0, 2);
                if (pick == 0) k = 1;
                else k = tag_at[pick - 1] + 1;
                if ($urandom_range(0, 7) == 0) sig_buf[k] = 8'h80;
                else sig_buf[k] = 8'($urandom_range(8'h82, 8'hff));
            end
            FLAW_OVERSIZE: begin
                k = len_at[$urandom_range(0, 1)];
                if (sig_buf[k-1] == LONG_FORM_ONE)
                    sig_buf[k] = 8'($urandom_range(MAX_ELEMENT_BYTES + 1, 255));
                else
                    sig_buf[k] = 8'($urandom_range(MAX_ELEMENT_BYTES + 1, 127));
            end
            FLAW_EARLY_END: begin
                n = $urandom_range(1, sig_buf.size() - 1);
                while (sig_buf.size() > n) void'(sig_buf.pop_back());
            end
            FLAW_NOISE: begin
                sig_buf = {};
                repeat ($urandom_range(1, 12)) sig_buf = {sig_buf, 8'($urandom)};
            end
            default: begin
            end
        endcase
        send_sig();
    endtask

    // Blocks until every queued byte has been taken and every owed result has arrived.
    task automatic wait_all_delivered();
        while (pending_der.size() != 0 || in_busy || expected_raw.size() != 0)
            @(posedge i_clk);
    endtask

    // Input driver: offers one DER byte per beat, changing only at the falling edge.
    // A byte stays on the bus until the monitor reports it taken; a gap drawn per byte
    // then holds valid low, unless the next byte follows straight on.
    always @(negedge i_clk) begin
        t_der_beat beat;
        if (i_rst_n) begin
            if (byte_taken) begin
                in_busy    = 1'b0;
                byte_taken = 1'b0;
            end
            if (!in_busy) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (pending_der.size() != 0) begin
                    beat = pending_der.pop_front();
                    i_in_byte <= beat.b;
                    i_in_last <= beat.last;
                    in_busy = 1'b1;
                    in_gap  = idle_on ? $urandom_range(0, 7) : 0;
                end
            end
            i_in_valid <= in_busy;
        end
    end

    // Receiver: stalls for a randomly drawn number of cycles after each result beat, and
    // for one long stretch when asked, so that the block backs up into its input.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_wait != 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: samples both channels at the rising edge. Result beats are checked before
    // the input beat of the same edge is folded into the prediction.
    always @(posedge i_clk) begin
        t_raw_beat want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_raw.size() == 0) begin
                    $error("result beat with nothing expected: out_byte %h last %b error %b",
                           o_out_byte, o_out_last, o_out_error);
                    fail_count++;
                end else begin
                    want = expected_raw.pop_front();
                    if (o_out_byte !== want.b) begin
                        $error("out_byte: expected %h, got %h", want.b, o_out_byte);
                        fail_count++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, o_out_last);
                        fail_count++;
                    end
                    if (o_out_error !== want.err) begin
                        $error("out_error: expected %b, got %b", want.err, o_out_error);
                        fail_count++;
                    end
                    if (want.err) err_checked++;
                    else raw_checked++;
                end
                out_wait = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                convert_der_beat(i_in_byte, i_in_last);
                byte_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d result beats outstanding.",
                     cycle_count, expected_raw.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        clear_parser();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed signatures, with random idling on both sides.
        idle_on = 1'b1;
        // Both integers empty: the raw output is all zeros.
        sig_buf = '{TAG_SEQUENCE, 8'h04, TAG_INTEGER, 8'h00, TAG_INTEGER, 8'h00};
        send_sig();
        // A lone byte that is not a sequence tag.
        sig_buf = '{8'h31};
        send_sig();
        // One-byte long form on the sequence and R lengths, plus a trailing byte inside the sequence.
        sig_buf = '{TAG_SEQUENCE, LONG_FORM_ONE, 8'h08, TAG_INTEGER, LONG_FORM_ONE, 8'h01,
                    8'hff, TAG_INTEGER, 8'h01, 8'h80, 8'haa};
        send_sig();
        // Integer longer than any value the register can hold.
        sig_buf = '{TAG_SEQUENCE, 8'h02, TAG_INTEGER, 8'h22};
        send_sig();
        // Two-byte long form on the sequence length is not supported.
        sig_buf = '{TAG_SEQUENCE, 8'h82};
        send_sig();
        // Signature ends straight after its tag.
        sig_buf = '{TAG_SEQUENCE};
        send_sig();
        wait_all_delivered();

        // Back-to-back traffic with no idling on either side.
        idle_on = 1'b0;
        while (bytes_sent < 90) random_signature(1'b0, 1'b1);
        wait_all_delivered();

        // Random idling, plus a sequence long enough that its one-byte long form length
        // lies above 0x7f, with both integers at full width.
        idle_on = 1'b1;
        while (bytes_sent < 150) random_signature(1'b0, 1'b1);
        build_sig(HALF_BYTES, MAX_ELEMENT_BYTES, 130 - 6 - HALF_BYTES - MAX_ELEMENT_BYTES,
                  1'b1, 1'b0, 1'b0);
        send_sig();
        wait_all_delivered();

        // The receiver holds off for a long stretch while short, well-formed signatures
        // keep coming, so the second one fills the spare bank and its final byte stalls.
        hold_req = 1'b1;
        repeat (4) random_signature(1'b1, 1'b0);
        while (bytes_sent < 360) random_signature(1'b0, 1'b1);
        wait_all_delivered();

        // Keep the clock running after the last result beat to show that nothing unexpected follows.
        repeat (16) @(posedge i_clk);

        $display("Sent %0d signatures (%0d DER bytes) with and without idling and one long",
                 sigs_sent, bytes_sent);
        $display("receiver hold-off; checked %0d raw bytes and %0d error results.",
                 raw_checked, err_checked);
        if (fail_count == 0 && expected_raw.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
